// File: hdl/rcb25_pkg.sv
// ----------------------------------------------------------------------------
// rcb25_pkg
// Shared types and constants of the base-25 referral code codec: key
// alphabet, reciprocal constant for divide-by-25 and the per-cell beat type.
// ----------------------------------------------------------------------------
package rcb25_pkg;

    localparam int unsigned KEY_LEN   = 25;
    localparam int unsigned CODE_LEN  = 7;
    localparam int unsigned NUM_IN_W  = 31;
    localparam int unsigned NUM_OUT_W = 33;
    localparam int unsigned CODE_W    = 8 * CODE_LEN;
    localparam int unsigned DIGIT_W   = 5;
    localparam int unsigned KIDX_W    = 6;

    // floor(v / 25) == (v * DIV25_MAGIC) >> DIV25_SHIFT for every v < 2**32
    localparam logic [31:0] DIV25_MAGIC = 32'h51EB_851F;
    localparam int unsigned DIV25_SHIFT = 35;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // "QWERTYUOPASDFGHJKLZXCVBNM"
    localparam logic [7:0] KEY_CHARS [KEY_LEN] = '{
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h4F, 8'h50, 8'h41,
        8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h5A, 8'h58,
        8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D
    };

    // code of zero: "QWERTYU"
    localparam logic [CODE_W-1:0] ZERO_CODE = 56'h51_57_45_52_54_59_55;

    typedef struct packed {
        logic                 op;
        logic                 ok;
        logic [NUM_IN_W-1:0]  number_in;
        logic [NUM_OUT_W-1:0] acc;
        logic [CODE_W-1:0]    code;
    } t_stage;

    // key alphabet repeated twice, idx in 0..49
    function automatic logic [7:0] key_char(input logic [KIDX_W-1:0] idx);
        logic [KIDX_W-1:0] wrapped;
        wrapped = (idx >= KIDX_W'(KEY_LEN)) ? idx - KIDX_W'(KEY_LEN) : idx;
        return KEY_CHARS[wrapped[DIGIT_W-1:0]];
    endfunction

endpackage

// File: hdl/rcb25_if.sv
// ----------------------------------------------------------------------------
// rcb25 channel interfaces
// Valid/ready channels for the codec request and result beats.
// ----------------------------------------------------------------------------
interface rcb25_in_if;
    import rcb25_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [NUM_IN_W-1:0] number_in;
    logic [CODE_W-1:0]   code_in;

    modport source (output valid, output op, output number_in, output code_in,
                    input ready);
    modport sink   (input valid, input op, input number_in, input code_in,
                    output ready);
endinterface

interface rcb25_out_if;
    import rcb25_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [NUM_OUT_W-1:0] number_out;
    logic [CODE_W-1:0]    code_out;
    logic                 valid_res;

    modport source (output valid, output number_out, output code_out,
                    output valid_res, input ready);
    modport sink   (input valid, input number_out, input code_out,
                    input valid_res, output ready);
endinterface

// File: hdl/referral_code_base25_codec.sv
// ----------------------------------------------------------------------------
// referral_code_base25_codec
// Converts between a 31-bit ID and a 7-letter base-25 referral code, both
// directions, over a chain of seven digit cells.
// ----------------------------------------------------------------------------
// Takes one request beat per clock and returns one result beat per request,
// in order. The request walks a chain of seven digit cells, one base-25
// digit per cell, and the last cell's register drives the result channel.
// A stalled result holds the chain in place; cells with free slots keep
// filling, so accept continues until all seven registers are full.
// Encode (op 0) returns number_in, its code and valid_res 1. Decode (op 1)
// returns the 33-bit value and code_in, or 0, "QWERTYU" and valid_res 0 when
// any byte is not a key letter.
module referral_code_base25_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcb25_in_if.sink    i_in,
    rcb25_out_if.source o_out
);
    import rcb25_pkg::*;

    logic   valid [CODE_LEN+1];
    logic   ready [CODE_LEN+1];
    t_stage data  [CODE_LEN+1];
    t_stage last;

    always_comb begin
        data[0].op        = i_in.op;
        data[0].ok        = 1'b1;
        data[0].number_in = i_in.number_in;
        data[0].acc       = (i_in.op == OP_ENCODE) ? NUM_OUT_W'(i_in.number_in) : '0;
        data[0].code      = (i_in.op == OP_ENCODE) ? '0 : i_in.code_in;
    end

    assign valid[0]   = i_in.valid;
    assign i_in.ready = ready[0];

    for (genvar s = 0; s < CODE_LEN; s++) begin : g_cell
        rcb25_cell #(
            .STAGE (s)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[s]),
            .o_ready (ready[s]),
            .i_data  (data[s]),
            .o_valid (valid[s+1]),
            .i_ready (ready[s+1]),
            .o_data  (data[s+1])
        );
    end

    assign last               = data[CODE_LEN];
    assign o_out.valid        = valid[CODE_LEN];
    assign ready[CODE_LEN]    = o_out.ready;

    always_comb begin
        if (last.op == OP_ENCODE) begin
            o_out.number_out = NUM_OUT_W'(last.number_in);
            o_out.code_out   = last.code;
            o_out.valid_res  = 1'b1;
        end else if (last.ok) begin
            o_out.number_out = last.acc;
            o_out.code_out   = last.code;
            o_out.valid_res  = 1'b1;
        end else begin
            o_out.number_out = '0;
            o_out.code_out   = ZERO_CODE;
            o_out.valid_res  = 1'b0;
        end
    end

endmodule

// File: hdl/rcb25_cell.sv
// ----------------------------------------------------------------------------
// rcb25_cell
// One digit cell of the codec chain. Encode: peels the low base-25 digit off
// the running value and writes its letter. Decode: looks up the letter at
// this position and folds its digit into the running value.
// ----------------------------------------------------------------------------
module rcb25_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rcb25_pkg::t_stage i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rcb25_pkg::t_stage o_data
);
    import rcb25_pkg::*;

    localparam int unsigned ENC_POS = CODE_LEN - 1 - STAGE;
    localparam int unsigned ENC_LSB = 8 * STAGE;
    localparam int unsigned DEC_POS = STAGE;
    localparam int unsigned DEC_LSB = 8 * (CODE_LEN - 1 - STAGE);

    logic                 r_valid;
    t_stage               r_data;
    t_stage               n_data;

    logic [NUM_IN_W-1:0]  enc_v;
    logic [62:0]          enc_prod;
    logic [NUM_IN_W-1:0]  enc_q;
    logic [NUM_IN_W-1:0]  enc_q25;
    logic [NUM_IN_W-1:0]  enc_rem;
    logic [KIDX_W-1:0]    enc_idx;

    logic [7:0]           dec_ch;
    logic                 dec_found;
    logic [DIGIT_W-1:0]   dec_digit;
    logic [NUM_OUT_W-1:0] dec_acc25;

    // encode: divide by 25 via reciprocal
    always_comb begin
        enc_v    = i_data.acc[NUM_IN_W-1:0];
        enc_prod = enc_v * DIV25_MAGIC;
        enc_q    = NUM_IN_W'(enc_prod[62:DIV25_SHIFT]);
        enc_q25  = (enc_q << 4) + (enc_q << 3) + enc_q;
        enc_rem  = enc_v - enc_q25;
        enc_idx  = KIDX_W'(enc_rem[DIGIT_W-1:0]) + KIDX_W'(ENC_POS);
    end

    // decode: first match in the rotated window
    always_comb begin
        dec_ch    = i_data.code[DEC_LSB +: 8];
        dec_found = 1'b0;
        dec_digit = '0;
        for (int k = 0; k < KEY_LEN; k++) begin
            if (!dec_found && key_char(KIDX_W'(DEC_POS + k)) == dec_ch) begin
                dec_found = 1'b1;
                dec_digit = DIGIT_W'(k);
            end
        end
        dec_acc25 = (i_data.acc << 4) + (i_data.acc << 3) + i_data.acc;
    end

    always_comb begin
        n_data = i_data;
        if (i_data.op == OP_ENCODE) begin
            n_data.acc                  = NUM_OUT_W'(enc_q);
            n_data.code[ENC_LSB +: 8]   = key_char(enc_idx);
        end else begin
            n_data.acc = dec_acc25 + NUM_OUT_W'(dec_digit);
            n_data.ok  = i_data.ok & dec_found;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
